>>> rtl/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned Rounds = 64;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned TotalW = 61;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } rsp_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[r];
  endfunction

  // Initial hash values.
  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha256_stream_hasher.sv
`default_nettype none
// SHA-256 byte-stream hasher. Each accepted request carries at most one message
// byte. A byte that does not complete a 64-byte block leaves the block ready for
// the next request. The 64th byte of a block starts a compression, and no request
// is taken until it is done: the load state fills the schedule window from the
// 16-entry block memory, which has a registered read; the round state runs the 64
// rounds, one per cycle; and the add state adds the result into the hash.
// A request flagged end_of_message pads the block. Padding writes each byte slot
// from the pad byte up to slot 55, then writes the two length words, and runs the
// final compression. When the pad byte lands in slot 56 or later, the block is
// zero-filled to slot 63 and compressed first, and then a second block of zeros
// up to slot 55 and the two length words follows. Eight digest words
// come out next, one per accepted response, the first holding the most
// significant bytes and the eighth flagged digest_last. The hash state then
// returns to the initial values.
module sha256_stream_hasher (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic                     in_ready_o,
  input  wire sha256_pkg::req_t   in_req_i,
  output logic                     out_valid_o,
  input  wire                logic out_ready_i,
  output sha256_pkg::rsp_t         out_rsp_o
);
  import sha256_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StPad   = 6'b000010,
    StLoad  = 6'b000100,
    StRound = 6'b001000,
    StAdd   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Block memory: sixteen words, one write and one registered read per cycle.
  logic [31:0] blk_mem [BlockWords];
  logic        mem_we;
  logic [3:0]  mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= blk_mem[mem_raddr];
  end

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];   // schedule window, shifted each round
  logic [TotalW-1:0] total_q;
  logic [5:0] pos_q;
  logic [6:0] rnd_q;
  logic [4:0] ld_q;        // load counter, 0..17
  logic       final_q;     // current compression is the last one
  logic       msg_end_q;   // message has ended; cleared after the last digest word
  logic       len_q;       // high word of the length written, low word next
  logic       pad_first_q; // next pad byte is the 0x80 marker
  logic [2:0] oidx_q;
  logic [31:0] word_q;     // word being assembled
  logic [31:0] wbuf;

  // Byte merge into the word held for the current slot.
  function automatic logic [31:0] merge(input logic [31:0] w, input logic [1:0] p,
                                        input logic [7:0] b);
    logic [31:0] m;
    m = w;
    m[(3 - p) * 8 +: 8] = b;
    return m;
  endfunction

  assign in_ready_o = (state_q == StIdle);
  wire accept = in_valid_i && in_ready_o;

  // Padding byte and the two words of the bit length.
  logic [7:0] pad_b;
  logic [31:0] bits_hi, bits_lo;
  assign bits_hi = {total_q[TotalW-1:29]};
  assign bits_lo = {total_q[28:0], 3'b000};

  logic [31:0] new_w, s0, s1, t1, t2;
  always_comb begin
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    new_w = (rnd_q < 7'd16) ? w_q[0] : (w_q[0] + s0 + w_q[9] + s1);
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q[5:0]) + new_w;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Control and memory port selection.
  always_comb begin
    state_d = state_q;
    mem_we = 1'b0;
    mem_waddr = pos_q[5:2];
    mem_wdata = '0;
    mem_raddr = ld_q[3:0];
    pad_b = pad_first_q ? PadByte : 8'h00;
    wbuf = (pos_q[1:0] == 2'd0) ? 32'h0 : word_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          mem_wdata = merge(wbuf, pos_q[1:0], in_req_i.data_byte);
          mem_we = in_req_i.has_byte;
          if (in_req_i.has_byte && pos_q == 6'd63) begin
            state_d = StLoad;
          end else if (in_req_i.end_of_message) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        mem_we = 1'b1;
        if (len_q) begin
          mem_waddr = 4'd15;
          mem_wdata = bits_lo;
          state_d = StLoad;
        end else if (!pad_first_q && pos_q == LenPos) begin
          mem_waddr = 4'd14;
          mem_wdata = bits_hi;
        end else begin
          mem_wdata = merge(wbuf, pos_q[1:0], pad_b);
          if (pos_q == 6'd63) begin
            state_d = StLoad;
          end
        end
      end
      StLoad: begin
        if (ld_q == 5'd16) begin
          state_d = StRound;
        end
      end
      StRound: begin
        if (rnd_q == 7'd63) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        state_d = final_q ? StOut : (msg_end_q ? StPad : StIdle);
      end
      StOut: begin
        if (out_ready_i && oidx_q == 3'd7) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q <= '0;
      total_q <= '0;
      rnd_q <= '0;
      ld_q <= '0;
      final_q <= 1'b0;
      msg_end_q <= 1'b0;
      len_q <= 1'b0;
      oidx_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            ld_q <= '0;
            if (in_req_i.has_byte) begin
              word_q <= merge(wbuf, pos_q[1:0], in_req_i.data_byte);
              pos_q <= pos_q + 6'd1;
              total_q <= total_q + TotalW'(1);
            end
            // Padding follows once any full block has been compressed.
            final_q <= 1'b0;
            len_q <= 1'b0;
            msg_end_q <= in_req_i.end_of_message;
          end
        end
        StPad: begin
          ld_q <= '0;
          if (len_q) begin
            len_q <= 1'b0;
            final_q <= 1'b1;
            pos_q <= '0;
          end else if (!pad_first_q && pos_q == LenPos) begin
            len_q <= 1'b1;
          end else begin
            word_q <= merge(wbuf, pos_q[1:0], pad_b);
            pos_q <= pos_q + 6'd1;
          end
        end
        StLoad: begin
          ld_q <= ld_q + 5'd1;
          if (ld_q != 5'd0) begin
            w_q[15] <= mem_rdata_q;
            for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          end
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          rnd_q <= '0;
        end
        StRound: begin
          rnd_q <= rnd_q + 7'd1;
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= new_w;
          v_q[0] <= t1 + t2;
          v_q[1] <= v_q[0];
          v_q[2] <= v_q[1];
          v_q[3] <= v_q[2];
          v_q[4] <= v_q[3] + t1;
          v_q[5] <= v_q[4];
          v_q[6] <= v_q[5];
          v_q[7] <= v_q[6];
        end
        StAdd: begin
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          oidx_q <= '0;
        end
        StOut: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
              total_q <= '0;
              pos_q <= '0;
              final_q <= 1'b0;
              msg_end_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = (state_q == StOut);
  assign out_rsp_o.digest_word = h_q[oidx_q];
  assign out_rsp_o.digest_last = (oidx_q == 3'd7);

  // Padding state bookkeeping: the first pad byte is 0x80.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_first_q <= 1'b0;
    end else if (accept) begin
      pad_first_q <= in_req_i.end_of_message;
    end else if (state_q == StPad) begin
      pad_first_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> rtl/sha256_checker.sv
`default_nettype none
module sha256_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire sha256_pkg::req_t in_req_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire sha256_pkg::rsp_t out_rsp_o
);
  // No request is taken while digest words are pending.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready during digest output");

  // After the last digest word the block is ready again.
  a_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_rsp_o.digest_last |=> in_ready_o && !out_valid_o)
    else $error("no return to idle after digest");

  // A stalled word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("digest word changed while stalled");

  // A request without byte and without end leaves the block ready in the next cycle.
  a_nop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_req_i.has_byte && !in_req_i.end_of_message
    |=> in_ready_o) else $error("empty request stalled the block");
endmodule

bind sha256_stream_hasher sha256_checker u_chk (.*);
`default_nettype wire

>>> dv/sha256_stream_checker.sv
module sha256_stream_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  sha256_pkg::req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  sha256_pkg::rsp_t  out_rsp_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       digest_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::*;

  localparam logic [31:0] RoundKey [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0]      chain [8];
  logic [7:0]       msg_buf [64];
  logic [TotalW-1:0] msg_len;
  logic [5:0]       fill;
  rsp_t             digest_q [$];
  int unsigned      fails;

  assign fail_count_o = fails;
  assign pending_o = digest_q.size();

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // One compression of the 64-byte buffer into the chaining value.
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = chain;
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundKey[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  // Absorb one request; on end of message, pad and queue the digest words.
  task automatic absorb(input req_t rq);
    int pos;
    logic [63:0] bits;
    rsp_t rs;
    if (rq.has_byte) begin
      msg_buf[fill] = rq.data_byte;
      fill = fill + 6'd1;
      msg_len = msg_len + 1'b1;
      if (fill == 6'd0) compress();
    end
    if (rq.end_of_message) begin
      pos = fill;
      msg_buf[pos] = PadByte;
      pos++;
      if (pos > LenPos) begin
        while (pos < 64) begin msg_buf[pos] = 8'h00; pos++; end
        compress();
        pos = 0;
      end
      while (pos < LenPos) begin msg_buf[pos] = 8'h00; pos++; end
      bits = {msg_len, 3'b000};
      for (int i = 0; i < 8; i++) msg_buf[56+i] = bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        rs.digest_word = chain[i];
        rs.digest_last = (i == 7);
        digest_q.push_back(rs);
      end
      chain = StartHash;
      msg_len = '0;
      fill = '0;
    end
  endtask

  // Model requests and compare digest words as the handshakes complete.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      chain = StartHash;
      msg_len = '0;
      fill = '0;
      digest_q.delete();
      fails = 0;
      digest_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $error("digest word %h with no word expected", out_rsp_i.digest_word);
          fails++;
        end else begin
          exp_rsp = digest_q.pop_front();
          if (out_rsp_i.digest_word !== exp_rsp.digest_word) begin
            $error("digest_word: expected %h, got %h", exp_rsp.digest_word,
                   out_rsp_i.digest_word);
            fails++;
          end
          if (out_rsp_i.digest_last !== exp_rsp.digest_last) begin
            $error("digest_last: expected %b, got %b", exp_rsp.digest_last,
                   out_rsp_i.digest_last);
            fails++;
          end
          if (exp_rsp.digest_last) digest_count_o++;
        end
      end
      if (in_valid_i && in_ready_i) absorb(in_req_i);
    end
  end

endmodule

>>> dv/sha256_stream_hasher_test.sv
module sha256_stream_hasher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  req_t        in_req;
  logic        out_valid;
  logic        out_ready;
  rsp_t        out_rsp;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned digest_count;
  int unsigned idle_cycles;
  int unsigned request_count;
  int unsigned stall_mode;

  sha256_stream_hasher i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  sha256_stream_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_rsp_i     (out_rsp),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .digest_count_o(digest_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver stall pattern: phases of always ready, random and mostly stalled.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Send one request and wait for its handshake; gap_max adds idle cycles first.
  task automatic send(input logic [7:0] b, input logic hb, input logic eom,
                      input int unsigned gap_max);
    int unsigned gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= '{data_byte: b, has_byte: hb, end_of_message: eom};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    request_count++;
  endtask

  // A message of random bytes in bursts, optionally sprinkled with empty requests.
  task automatic send_message(input int unsigned len, input bit noisy,
                              input bit byte_on_last);
    int unsigned burst;
    burst = 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (burst == 0) burst = $urandom_range(1, 24);
      if (noisy && $urandom_range(0, 7) == 0)
        send(8'($urandom), 1'b0, 1'b0, 0);
      send(8'($urandom), 1'b1, 1'b0, (burst == 1) ? 4 : 0);
      burst--;
    end
    send(8'($urandom), byte_on_last, 1'b1, 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    int unsigned len;
    in_valid = 1'b0;
    in_req = '0;
    rst_n = 1'b0;
    request_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, single extreme bytes, a one-byte message among empty requests.
    send(8'h00, 1'b0, 1'b1, 0);
    send(8'hff, 1'b1, 1'b1, 0);
    send(8'h00, 1'b1, 1'b1, 0);
    send(8'h5a, 1'b0, 1'b0, 0);
    send(8'ha5, 1'b1, 1'b0, 0);
    send(8'h3c, 1'b0, 1'b1, 0);
    drain();

    // Lengths around the one-or-two padding block boundary.
    send_message(54, 1'b0, 1'b1);
    send_message(55, 1'b0, 1'b1);
    send_message(56, 1'b0, 1'b0);
    send_message(63, 1'b0, 1'b1);
    send_message(64, 1'b0, 1'b0);
    drain();

    // Random messages, mostly short, with byte or no byte on the last request.
    while (request_count < 310) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 12);
      send_message(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();

    $display("Covered %0d requests and %0d digests, including empty and block-edge lengths.",
             request_count, digest_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sha256_stream_hasher.f
rtl/sha256_pkg.sv
rtl/sha256_stream_hasher.sv
rtl/sha256_checker.sv
dv/sha256_stream_checker.sv
dv/sha256_stream_hasher_test.sv
